[design/sprite_framebuffer_led_serializer_defines.svh]
// Assertion macros for the sprite frame buffer LED serialiser.
// Used by the top level; expects clk and rst_n in scope. SYNTH builds get empty bodies.
`ifndef SPRITE_FRAMEBUFFER_LED_SERIALIZER_DEFINES_SVH
`define SPRITE_FRAMEBUFFER_LED_SERIALIZER_DEFINES_SVH
`ifndef SYNTH
`define SFLS_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sfls assertion failed");
`define SFLS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfls assertion failed");
`else
`define SFLS_ASSERT_NEVER(name, cond)
`define SFLS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

[design/sfls_pkg.sv]
// Shared types and constants for the sprite frame buffer LED serialiser.
// No dependencies; used by the front, back and top level.
package sfls_pkg;

  localparam logic [1:0] OP_DRAW    = 2'd0;
  localparam logic [1:0] OP_CLEAR   = 2'd1;
  localparam logic [1:0] OP_REFRESH = 2'd2;

  localparam logic [7:0]  HDR_BASE      = 8'hE0;
  localparam logic [4:0]  LEVEL_MAX     = 5'd31;
  localparam logic [8:0]  FULL_SCALE    = 9'd256;
  localparam logic [8:0]  BRIGHT_RESET  = 9'd26;
  localparam logic [2:0]  END_LAST      = 3'd6;
  localparam logic [1:0]  CH_LAST       = 2'd2;
  localparam logic [23:0] RGB_ZERO      = 24'h000000;

  // Classified command handed from front to back
  typedef struct packed {
    logic        draw;
    logic        dark;
    logic [2:0]  row;
    logic [3:0]  col;
    logic [23:0] data;
  } cmd_t;

  typedef struct packed {
    logic streaming;
    logic push_last;
  } back_stat_t;

endpackage

[design/sfls_ram.sv]
// Generic single-write, single-read RAM with registered read and read enable.
// No dependencies.
module sfls_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 84
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/sfls_fifo.sv]
// Two-entry register queue with push/full and pop/empty sides.
// No dependencies; used for the command queue and the byte queue.
module sfls_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[design/sfls_front.sv]
// Front end: takes input items, drops those with no effect, builds commands.
// Depends on sfls_pkg and sfls_fifo (command queue towards the back end).
module sfls_front #(
  parameter int COLUMNS = 12,
  parameter int ROWS    = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          in_op,
  input  logic [3:0]          in_origin_x,
  input  logic [2:0]          in_origin_y,
  input  logic [3:0]          in_sprite_col,
  input  logic [2:0]          in_sprite_row,
  input  logic [23:0]         in_sprite_pixel,
  input  logic [23:0]         in_tint_color,
  input  logic [2:0]          in_target_row,
  input  logic                cmd_pop,
  output logic                cmd_valid,
  output sfls_pkg::cmd_t      cmd
);

  logic [4:0]     x;
  logic [3:0]     y;
  logic           keep;
  logic           cmd_empty;
  sfls_pkg::cmd_t new_cmd;

  assign x = {1'b0, in_origin_x} + {1'b0, in_sprite_col};
  assign y = {1'b0, in_origin_y} + {1'b0, in_sprite_row};

  always_comb begin
    new_cmd.draw = 1'b0;
    new_cmd.dark = 1'b0;
    new_cmd.row  = in_target_row;
    new_cmd.col  = x[3:0];
    new_cmd.data = in_sprite_pixel;
    keep         = 1'b0;
    case (in_op)
      sfls_pkg::OP_DRAW: begin
        new_cmd.draw = 1'b1;
        new_cmd.row  = y[2:0];
        // tint replaces only lit pixels
        if ((in_sprite_pixel != sfls_pkg::RGB_ZERO) && (in_tint_color != sfls_pkg::RGB_ZERO)) begin
          new_cmd.data = in_tint_color;
        end
        keep = (x < 5'(COLUMNS)) && (y < 4'(ROWS));
      end
      sfls_pkg::OP_CLEAR: begin
        new_cmd.dark = 1'b1;
        keep         = ({1'b0, in_target_row} < 4'(ROWS));
      end
      sfls_pkg::OP_REFRESH: begin
        keep = ({1'b0, in_target_row} < 4'(ROWS));
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  sfls_fifo #(
    .WIDTH ($bits(sfls_pkg::cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push && keep),
    .wdata (new_cmd),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;

endmodule

[design/sfls_back.sv]
// Back end: frame store, draw writes and the APA102 row byte sequencer.
// Depends on sfls_pkg, sfls_ram (frame store) and sfls_fifo (byte queue).
module sfls_back #(
  parameter int COLUMNS = 12,
  parameter int ROWS    = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [8:0]              bright,
  input  logic                    cmd_valid,
  input  sfls_pkg::cmd_t          cmd,
  output logic                    cmd_pop,
  input  logic                    pop,
  output logic                    empty,
  output logic [7:0]              out_byte_out,
  output logic                    out_last,
  output sfls_pkg::back_stat_t    stat
);

  localparam int PIX = COLUMNS * ROWS;
  localparam int AW  = (PIX > 1) ? $clog2(PIX) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_HDR,
    S_CH,
    S_END
  } state_t;

  state_t          state_r;
  logic [3:0]      col_r;
  logic [1:0]      ch_r;
  logic [2:0]      cnt_r;
  logic [2:0]      row_r;
  logic            dark_r;
  logic            vld_rd_r;
  logic [PIX-1:0]  valid_r;

  logic            oq_full;
  logic            streaming;
  logic            push_b;
  logic            last_b;
  logic [7:0]      byte_b;
  logic            we;
  logic [AW-1:0]   waddr;
  logic            re;
  logic [AW-1:0]   raddr;
  logic [23:0]     rdata;
  logic [23:0]     px;
  logic [7:0]      chan;
  logic [16:0]     prod;
  logic [13:0]     lvl_prod;
  logic            clr_row;

  assign streaming = (state_r != S_IDLE);
  assign push_b    = streaming && !oq_full;
  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;
  assign we        = cmd_pop && cmd.draw;
  assign waddr     = AW'(int'(cmd.row) * COLUMNS + int'(cmd.col));
  assign raddr     = AW'(int'(row_r) * COLUMNS + int'(col_r));
  assign re        = push_b && (state_r == S_HDR);

  sfls_ram #(
    .WIDTH (24),
    .DEPTH (PIX)
  ) u_frame (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cmd.data),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Entries never written or cleared since read as black
  assign px = vld_rd_r ? rdata : sfls_pkg::RGB_ZERO;

  always_comb begin
    case (ch_r)
      2'd0:    chan = px[23:16];
      2'd1:    chan = px[15:8];
      default: chan = px[7:0];
    endcase
  end

  assign prod     = 17'(chan) * 17'(bright);
  assign lvl_prod = 14'(sfls_pkg::LEVEL_MAX) * 14'(bright);

  always_comb begin
    case (state_r)
      S_HDR:   byte_b = dark_r ? sfls_pkg::HDR_BASE
                               : (sfls_pkg::HDR_BASE | {3'b000, lvl_prod[12:8]});
      S_CH:    byte_b = dark_r ? 8'h00 : prod[15:8];
      default: byte_b = 8'h00;
    endcase
  end

  assign last_b = ((state_r == S_CH) && (ch_r == sfls_pkg::CH_LAST) &&
                   (col_r == 4'(COLUMNS - 1)) && (row_r != 3'(ROWS - 1))) ||
                  ((state_r == S_END) && (cnt_r == sfls_pkg::END_LAST));

  assign clr_row = push_b && last_b && dark_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      col_r    <= 4'd0;
      ch_r     <= 2'd0;
      cnt_r    <= 3'd0;
      row_r    <= 3'd0;
      dark_r   <= 1'b0;
      vld_rd_r <= 1'b0;
    end else begin
      if (re) begin
        vld_rd_r <= valid_r[raddr];
      end
      case (state_r)
        S_IDLE: begin
          if (cmd_valid && !cmd.draw) begin
            row_r   <= cmd.row;
            dark_r  <= cmd.dark;
            col_r   <= 4'd0;
            ch_r    <= 2'd0;
            cnt_r   <= 3'd0;
            state_r <= (cmd.row == 3'd0) ? S_START : S_HDR;
          end
        end
        S_START: begin
          if (push_b) begin
            state_r <= S_HDR;
          end
        end
        S_HDR: begin
          if (push_b) begin
            ch_r    <= 2'd0;
            state_r <= S_CH;
          end
        end
        S_CH: begin
          if (push_b) begin
            if (ch_r != sfls_pkg::CH_LAST) begin
              ch_r <= ch_r + 2'd1;
            end else if (col_r != 4'(COLUMNS - 1)) begin
              col_r   <= col_r + 4'd1;
              state_r <= S_HDR;
            end else if (row_r == 3'(ROWS - 1)) begin
              cnt_r   <= 3'd0;
              state_r <= S_END;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_END: begin
          if (push_b) begin
            if (cnt_r == sfls_pkg::END_LAST) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r <= cnt_r + 3'd1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // One valid bit per entry: set on draw, dropped on reset or row clear
  for (genvar i = 0; i < PIX; i++) begin : g_vld
    localparam int ER = i / COLUMNS;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (we && (waddr == AW'(i))) begin
        valid_r[i] <= 1'b1;
      end else if (clr_row && (row_r == 3'(ER))) begin
        valid_r[i] <= 1'b0;
      end
    end
  end

  sfls_fifo #(
    .WIDTH (9)
  ) u_byte_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push_b),
    .wdata ({last_b, byte_b}),
    .full  (oq_full),
    .pop   (pop),
    .rdata ({out_last, out_byte_out}),
    .empty (empty)
  );

  assign stat.streaming = streaming;
  assign stat.push_last = push_b && last_b;

endmodule

[design/sprite_framebuffer_led_serializer.sv]
// Channel   | handshake           | payload
// input     | push / full         | in_op, origin, sprite pos, pixel, tint, target row
// result    | pop / empty         | out_byte_out, out_last
// config    | valid / ready       | cfg_brightness (ready always high)
//
// A draw is one frame store write by the idle back end. A clear or refresh streams
// one byte per cycle from the row sequencer while the byte queue has room: 4*COLUMNS
// bytes, plus one for row 0 and seven after the last row, once the idle state takes
// the command; the frame store read port and the byte queue set that pace. Reset
// clears the frame store through per-entry valid bits at once, so no clearing pass.
// Either side may stall freely: two-entry command and byte queues decouple them.
//
// Top level of the sprite frame buffer LED serialiser.
// Depends on sfls_pkg, sfls_front, sfls_back and the assertion macro header.
`include "sprite_framebuffer_led_serializer_defines.svh"
module sprite_framebuffer_led_serializer #(
  parameter int COLUMNS = 12,
  parameter int ROWS    = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_origin_x,
  input  logic [2:0]  in_origin_y,
  input  logic [3:0]  in_sprite_col,
  input  logic [2:0]  in_sprite_row,
  input  logic [23:0] in_sprite_pixel,
  input  logic [23:0] in_tint_color,
  input  logic [2:0]  in_target_row,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_out,
  output logic        out_last,
  input  logic        valid,
  output logic        ready,
  input  logic [8:0]  cfg_brightness
);

  logic                  [8:0] brightness_r;
  logic                  [8:0] bright;
  logic                        cmd_valid;
  logic                        cmd_pop;
  sfls_pkg::cmd_t              cmd;
  sfls_pkg::back_stat_t        stat;

  assign ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= sfls_pkg::BRIGHT_RESET;
    end else if (valid) begin
      brightness_r <= cfg_brightness;
    end
  end

  // Values above full scale act as full scale
  assign bright = brightness_r[8] ? sfls_pkg::FULL_SCALE : brightness_r;

  sfls_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_op           (in_op),
    .in_origin_x     (in_origin_x),
    .in_origin_y     (in_origin_y),
    .in_sprite_col   (in_sprite_col),
    .in_sprite_row   (in_sprite_row),
    .in_sprite_pixel (in_sprite_pixel),
    .in_tint_color   (in_tint_color),
    .in_target_row   (in_target_row),
    .cmd_pop         (cmd_pop),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd)
  );

  sfls_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .bright       (bright),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .pop          (pop),
    .empty        (empty),
    .out_byte_out (out_byte_out),
    .out_last     (out_last),
    .stat         (stat)
  );

  `SFLS_ASSERT_NEVER(a_cmd_pop_empty, cmd_pop && !cmd_valid)
  `SFLS_ASSERT_NEXT(a_no_stray_byte, empty && !stat.streaming, empty)
  `SFLS_ASSERT_NEXT(a_last_ends_row, stat.push_last, !stat.streaming)

endmodule
